// ===== rtl/delimited_frame_checksum_deframer_assert.svh =====
// Assertion macros for the delimited frame checksum deframer.
// Expects clk and rst_n in the scope of every use; compiled out when SYNTH is set.
`ifndef DELIMITED_FRAME_CHECKSUM_DEFRAMER_ASSERT_SVH
`define DELIMITED_FRAME_CHECKSUM_DEFRAMER_ASSERT_SVH
`ifndef SYNTH
`define DFCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DFCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DFCD_ASSERT(lbl, prop, msg)
`define DFCD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/dfcd_pkg.sv =====
// Shared types and constants for the delimited frame checksum deframer.
// No dependencies.
package dfcd_pkg;

    localparam int PATTERN_MAX_DEF = 4;
    localparam int MAX_FRAME_DEF   = 255;

    // drop marker plus up to four start pattern bytes
    localparam int BURST_MAX = 5;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_ACCEPT   = 2'd1,
        KIND_MISMATCH = 2'd2,
        KIND_DROP     = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_PATTERN = 2'd0,
        CFG_START_LENGTH  = 2'd1,
        CFG_END_PATTERN   = 2'd2,
        CFG_END_LENGTH    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                           load;
        logic [CNT_W-1:0]               count;
        logic [BURST_MAX-1:0][1:0]      kind;
        logic [BURST_MAX-1:0][7:0]      data;
    } burst_t;

endpackage

// ===== rtl/dfcd_in_if.sv =====
// Byte input channel: valid/ready handshake with one received byte.
// No dependencies.
interface dfcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/dfcd_out_if.sv =====
// Result output channel: valid/ready handshake with kind, data and last.
// No dependencies.
interface dfcd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;

    modport source (output valid, output kind, output data, output last, input ready);
    modport sink (input valid, input kind, input data, input last, output ready);
endinterface

// ===== rtl/delimited_frame_checksum_deframer.sv =====
// The first result of a byte is offered in the cycle after its beat is accepted.
// Throughput: one byte per cycle while each byte causes at most one result and res is ready;
// a byte with more results holds the input until the one-beat-per-cycle result port drains them.
// Reset (rst_n low, asynchronous): patterns return to '$' and newline of length 1, the
// block goes idle with empty byte history, and any pending results are discarded.
module delimited_frame_checksum_deframer #(
    parameter int PATTERN_MAX = dfcd_pkg::PATTERN_MAX_DEF,
    parameter int MAX_FRAME   = dfcd_pkg::MAX_FRAME_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dfcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dfcd_pkg::CFG_W-1:0]     cfg_data,
    dfcd_in_if.sink                        rx,
    dfcd_out_if.source                     res
);

    dfcd_pkg::burst_t burst;
    logic             can_load;
    logic             accept;

    // Take a new byte whenever the result register is empty or hands over its
    // final beat in this cycle, so a waiting result never blocks the next byte
    // beyond its own drain.
    assign rx.ready = can_load;
    assign accept   = rx.valid && can_load;

    // Matching and frame state: update on each accepted beat, produce the burst
    // of results for that byte combinationally.
    dfcd_core #(
        .PATTERN_MAX (PATTERN_MAX),
        .MAX_FRAME   (MAX_FRAME)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .rx_byte   (rx.rx_byte),
        .burst     (burst)
    );

    // Result register: hold the burst and drain it one beat per cycle while res is ready, last
    // flag on the final result of each byte.
    dfcd_burst_buf u_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .burst    (burst),
        .can_load (can_load),
        .res      (res)
    );

endmodule

// ===== rtl/dfcd_core.sv =====
// Pattern matching, frame tracking and checksum digit check for one byte.
// Depends on dfcd_pkg and delimited_frame_checksum_deframer_assert.svh.
`include "delimited_frame_checksum_deframer_assert.svh"

module dfcd_core #(
    parameter int PATTERN_MAX = dfcd_pkg::PATTERN_MAX_DEF,
    parameter int MAX_FRAME   = dfcd_pkg::MAX_FRAME_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dfcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dfcd_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           accept,
    input  logic [7:0]                     rx_byte,
    output dfcd_pkg::burst_t               burst
);

    localparam int          CAP   = (PATTERN_MAX < 4) ? PATTERN_MAX : 4;
    localparam logic [2:0]  CAP_L = 3'(CAP);
    localparam logic [7:0]  MAX_L = 8'(MAX_FRAME);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FRAME = 2'd1,
        PH_SUM   = 2'd2
    } phase_t;

    logic [31:0] start_pattern_reg, end_pattern_reg;
    logic [2:0]  start_length_reg, end_length_reg;
    logic [31:0] recent_reg, recent_next;
    logic [2:0]  rvalid_reg, rvalid_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  flen_reg, flen_next;
    logic [1:0]  didx_reg, didx_next;
    logic        derr_reg, derr_next;

    function automatic logic [2:0] eff_len(input logic [2:0] len);
        logic [2:0] r;
        if (len == 3'd0)
        begin
            r = 3'd1;
        end
        else if (len > CAP_L)
        begin
            r = CAP_L;
        end
        else
        begin
            r = len;
        end
        return r;
    endfunction

    function automatic logic [31:0] len_mask(input logic [2:0] len);
        logic [31:0] m;
        case (len)
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    logic [2:0]  sl, el;
    logic [31:0] rb;
    logic [2:0]  rv;
    logic        start_hit, end_hit, drop;
    logic [2:0]  pos;
    logic [7:0]  pbyte, sacc;
    logic [1:0]  hund;
    logic [7:0]  r8;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens, units, digit;
    logic [7:0]  u8;
    logic [1:0]  nd;
    logic [2:0]  k1;
    logic [7:0]  expect_byte;

    always_comb
    begin
        recent_next = recent_reg;
        rvalid_next = rvalid_reg;
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        flen_next   = flen_reg;
        didx_next   = didx_reg;
        derr_next   = derr_reg;
        burst       = '0;
        burst.load  = accept;

        sl = eff_len(start_length_reg);
        el = eff_len(end_length_reg);
        rb = {recent_reg[23:0], rx_byte};
        rv = (rvalid_reg >= 3'd4) ? 3'd4 : rvalid_reg + 3'd1;
        start_hit = (rv >= sl) && (((rb ^ start_pattern_reg) & len_mask(sl)) == 32'd0);
        end_hit   = (rv >= el) && (((rb ^ end_pattern_reg) & len_mask(el)) == 32'd0);
        drop  = 1'b0;
        pos   = 3'd0;
        pbyte = 8'd0;
        sacc  = 8'd0;

        // decimal digits of the frame sum
        hund = (sum_reg >= 8'd200) ? 2'd2 : ((sum_reg >= 8'd100) ? 2'd1 : 2'd0);
        r8   = sum_reg - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0));
        rem  = r8[6:0];
        prod = 15'(rem) * 15'd205;
        tens = prod[14:11];
        u8   = {1'b0, rem} - (8'(tens) * 8'd10);
        units = u8[3:0];
        nd   = (sum_reg >= 8'd100) ? 2'd3 : ((sum_reg >= 8'd10) ? 2'd2 : 2'd1);
        if (nd == 2'd3)
        begin
            digit = (didx_reg == 2'd0) ? {2'b00, hund} :
                    ((didx_reg == 2'd1) ? tens : units);
        end
        else if (nd == 2'd2)
        begin
            digit = (didx_reg == 2'd0) ? tens : units;
        end
        else
        begin
            digit = units;
        end
        expect_byte = 8'd48 + 8'(digit);
        k1 = 3'(didx_reg) + 3'd1;

        if (phase_reg == PH_SUM)
        begin
            derr_next = derr_reg | (rx_byte != expect_byte);
            if (k1 >= 3'(nd))
            begin
                burst.count   = 3'd1;
                burst.kind[0] = derr_next ? dfcd_pkg::KIND_MISMATCH : dfcd_pkg::KIND_ACCEPT;
                phase_next    = PH_IDLE;
                didx_next     = 2'd0;
                derr_next     = 1'b0;
            end
            else
            begin
                didx_next = k1[1:0];
            end
        end
        else
        begin
            recent_next = rb;
            rvalid_next = rv;
            if (start_hit)
            begin
                // restart: forward the whole start pattern, oldest byte first
                drop = (phase_reg == PH_FRAME);
                if (drop)
                begin
                    burst.kind[0] = dfcd_pkg::KIND_DROP;
                end
                for (int j = 0; j < CAP; j++)
                begin
                    if (3'(j) < sl)
                    begin
                        pos   = sl - 3'd1 - 3'(j);
                        pbyte = rb[{pos[1:0], 3'b000} +: 8];
                        sacc  = sacc + pbyte;
                        if (drop)
                        begin
                            burst.data[j+1] = pbyte;
                        end
                        else
                        begin
                            burst.data[j] = pbyte;
                        end
                    end
                end
                burst.count = sl + {2'b00, drop};
                phase_next  = PH_FRAME;
                sum_next    = sacc;
                flen_next   = {5'b00000, sl};
            end
            else if (phase_reg == PH_FRAME)
            begin
                burst.count = 3'd1;
                if (flen_reg >= MAX_L)
                begin
                    burst.kind[0] = dfcd_pkg::KIND_DROP;
                    phase_next    = PH_IDLE;
                    sum_next      = 8'd0;
                    flen_next     = 8'd0;
                end
                else
                begin
                    burst.data[0] = rx_byte;
                    sum_next      = sum_reg + rx_byte;
                    flen_next     = flen_reg + 8'd1;
                end
            end

            // end pattern counts only when it lies wholly inside the frame
            if ((phase_next == PH_FRAME) && (flen_next >= {5'b00000, el}) && end_hit)
            begin
                phase_next  = PH_SUM;
                didx_next   = 2'd0;
                derr_next   = 1'b0;
                recent_next = 32'd0;
                rvalid_next = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pattern_reg <= 32'd36;
            start_length_reg  <= 3'd1;
            end_pattern_reg   <= 32'd10;
            end_length_reg    <= 3'd1;
            recent_reg        <= 32'd0;
            rvalid_reg        <= 3'd0;
            phase_reg         <= PH_IDLE;
            sum_reg           <= 8'd0;
            flen_reg          <= 8'd0;
            didx_reg          <= 2'd0;
            derr_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dfcd_pkg::CFG_START_PATTERN: start_pattern_reg <= cfg_data;
                    dfcd_pkg::CFG_START_LENGTH:  start_length_reg  <= cfg_data[2:0];
                    dfcd_pkg::CFG_END_PATTERN:   end_pattern_reg   <= cfg_data;
                    dfcd_pkg::CFG_END_LENGTH:    end_length_reg    <= cfg_data[2:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                recent_reg <= recent_next;
                rvalid_reg <= rvalid_next;
                phase_reg  <= phase_next;
                sum_reg    <= sum_next;
                flen_reg   <= flen_next;
                didx_reg   <= didx_next;
                derr_reg   <= derr_next;
            end
        end
    end

    `DFCD_ASSERT(a_sum_history_empty, (phase_reg != PH_SUM) || (rvalid_reg == 3'd0 && recent_reg == 32'd0), "byte history not empty during checksum digits")
    `DFCD_ASSERT(a_frame_len_bound, flen_reg <= MAX_L, "frame length above maximum")

endmodule

// ===== rtl/dfcd_burst_buf.sv =====
// Result register: holds the burst of results caused by one byte and drains it one beat
// per cycle while res.ready is high. Depends on dfcd_pkg, dfcd_out_if and the assertion header.
`include "delimited_frame_checksum_deframer_assert.svh"

module dfcd_burst_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  dfcd_pkg::burst_t  burst,
    output logic              can_load,
    dfcd_out_if.source        res
);

    logic [dfcd_pkg::CNT_W-1:0]                cnt_reg, cnt_next;
    logic [dfcd_pkg::BURST_MAX-1:0][1:0]       kind_reg, kind_next;
    logic [dfcd_pkg::BURST_MAX-1:0][7:0]       data_reg, data_next;
    logic                                      pop;

    assign res.valid = (cnt_reg != '0);
    assign res.last  = (cnt_reg == dfcd_pkg::CNT_W'(1));
    assign res.kind  = kind_reg[0];
    assign res.data  = data_reg[0];
    assign pop       = res.valid && res.ready;
    assign can_load  = (cnt_reg == '0) || (res.last && res.ready);

    always_comb
    begin
        cnt_next  = cnt_reg;
        kind_next = kind_reg;
        data_next = data_reg;
        if (burst.load)
        begin
            cnt_next  = burst.count;
            kind_next = burst.kind;
            data_next = burst.data;
        end
        else if (pop)
        begin
            // advance: shift the next result to the head
            cnt_next  = cnt_reg - dfcd_pkg::CNT_W'(1);
            kind_next = kind_reg >> 2;
            data_next = data_reg >> 8;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        data_reg <= data_next;
    end

    `DFCD_ASSERT(a_cnt_bound, cnt_reg <= dfcd_pkg::CNT_W'(dfcd_pkg::BURST_MAX), "burst count above depth")
    `DFCD_ASSERT_NEXT(a_drain_continues, pop && (cnt_reg > dfcd_pkg::CNT_W'(1)) && !burst.load, res.valid && (cnt_reg == $past(cnt_reg) - dfcd_pkg::CNT_W'(1)), "burst drain lost a result")

endmodule

// ===== tb/tb_delimited_frame_checksum_deframer.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the delimited frame checksum deframer: byte stream in, frame
// events out, checked beat by beat against an in-bench model. Uses dfcd_pkg and the
// dfcd_in_if / dfcd_out_if channel interfaces from the RTL.

module tb_delimited_frame_checksum_deframer;

    // Generous bound on the whole run, in clock cycles
    localparam int RUN_LIMIT = 500000;

    typedef enum logic [1:0] {
        HUNT,
        IN_FRAME,
        IN_DIGITS
    } deframe_state_t;

    typedef struct {
        dfcd_pkg::kind_t kind;
        logic [7:0]      data;
        logic            last;
    } deframe_beat_t;

    typedef bit [7:0] byte_q_t[$];

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [dfcd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dfcd_pkg::CFG_W-1:0]     cfg_data;

    dfcd_in_if  rx_ch();
    dfcd_out_if res_ch();

    delimited_frame_checksum_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_ch),
        .res       (res_ch)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Deframer model state: register copies plus the frame tracker.
    // ------------------------------------------------------------------
    bit [31:0]      st_pat;
    bit [2:0]       st_len;
    bit [31:0]      en_pat;
    bit [2:0]       en_len;
    bit [31:0]      hist;       // last four bytes seen, newest in bits 7..0
    int             hist_n;     // how many of them are valid
    deframe_state_t fstate;
    bit [7:0]       fsum;
    int             flen;
    int             dig_k;
    bit             dig_bad;

    // Frame events still owed by the block, oldest first
    deframe_beat_t  deframe_out_q[$];
    // Bytes waiting to be offered on the input channel
    byte_q_t        rx_stream_q;

    int n_queued    = 0;
    int n_accepted  = 0;
    int n_errors    = 0;
    int cycle_count = 0;

    int tx_gap, tx_calm;
    int sink_stall, sink_calm;
    deframe_beat_t want;

    // Pattern lengths of 0 act as 1; anything above the pattern width saturates.
    function automatic int eff_len(input bit [2:0] len);
        int cap;
        cap = (dfcd_pkg::PATTERN_MAX_DEF < 4) ? dfcd_pkg::PATTERN_MAX_DEF : 4;
        if (len == 3'd0) return 1;
        if (int'(len) > cap) return cap;
        return int'(len);
    endfunction

    function automatic bit hist_match(input bit [31:0] pat, input int len);
        bit [31:0] m;
        m = (len >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * len)) - 32'd1);
        return (hist_n >= len) && ((hist & m) == (pat & m));
    endfunction

    // Byte i of a packed pattern, first byte in the top used position.
    function automatic bit [7:0] pat_byte(input bit [31:0] pat, input int len, input int i);
        return pat[8 * (len - 1 - i) +: 8];
    endfunction

    // Advance the frame tracker by one received byte and append the events it causes.
    function automatic void deframe_step(input bit [7:0] b);
        deframe_beat_t burst[$];
        int            sl, el, nd, div, k;
        bit [7:0]      v;
        sl = eff_len(st_len);
        el = eff_len(en_len);
        if (fstate == IN_DIGITS)
        begin
            // Digits are compared most significant first, no leading zeros.
            nd = (fsum >= 100) ? 3 : ((fsum >= 10) ? 2 : 1);
            div = 1;
            for (k = dig_k + 1; k < nd; k++) div = div * 10;
            if (32'(b) != 32'h30 + (int'(fsum) / div) % 10) dig_bad = 1'b1;
            dig_k++;
            if (dig_k >= nd)
            begin
                if (dig_bad) burst.push_back('{dfcd_pkg::KIND_MISMATCH, 8'h00, 1'b0});
                else burst.push_back('{dfcd_pkg::KIND_ACCEPT, 8'h00, 1'b0});
                fstate  = HUNT;
                dig_k   = 0;
                dig_bad = 1'b0;
            end
        end
        else
        begin
            hist = {hist[23:0], b};
            if (hist_n < 4) hist_n++;
            if (hist_match(st_pat, sl))
            begin
                // A start inside a frame drops it; the start bytes open the new one.
                if (fstate == IN_FRAME) burst.push_back('{dfcd_pkg::KIND_DROP, 8'h00, 1'b0});
                fstate = IN_FRAME;
                fsum   = '0;
                for (k = sl - 1; k >= 0; k--)
                begin
                    v = hist[8 * k +: 8];
                    burst.push_back('{dfcd_pkg::KIND_BYTE, v, 1'b0});
                    fsum += v;
                end
                flen = sl;
            end
            else if (fstate == IN_FRAME)
            begin
                if (flen >= dfcd_pkg::MAX_FRAME_DEF)
                begin
                    burst.push_back('{dfcd_pkg::KIND_DROP, 8'h00, 1'b0});
                    fstate = HUNT;
                    fsum   = '0;
                    flen   = 0;
                end
                else
                begin
                    burst.push_back('{dfcd_pkg::KIND_BYTE, b, 1'b0});
                    fsum += b;
                    flen++;
                end
            end
            // The end pattern counts only when all of it lies inside the frame.
            if (fstate == IN_FRAME && flen >= el && hist_match(en_pat, el))
            begin
                fstate  = IN_DIGITS;
                dig_k   = 0;
                dig_bad = 1'b0;
                hist    = '0;
                hist_n  = 0;
            end
        end
        if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i]) deframe_out_q.push_back(burst[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders: they only append to the byte stream.
    // ------------------------------------------------------------------
    function automatic void push_byte(input bit [7:0] b);
        rx_stream_q.push_back(b);
        n_queued++;
    endfunction

    // Random byte that belongs to neither pattern, so a body cannot end a frame early.
    function automatic bit [7:0] clean_byte();
        bit [7:0] c;
        bit       hit;
        int       sl, el, k;
        sl = eff_len(st_len);
        el = eff_len(en_len);
        do
        begin
            c   = 8'($urandom_range(0, 255));
            hit = 1'b0;
            for (k = 0; k < sl; k++) if (c == pat_byte(st_pat, sl, k)) hit = 1'b1;
            for (k = 0; k < el; k++) if (c == pat_byte(en_pat, el, k)) hit = 1'b1;
        end
        while (hit);
        return c;
    endfunction

    // Pattern bytes lean toward ASCII digits so that digit bytes get tested as patterns.
    function automatic bit [31:0] rand_pattern();
        bit [31:0] p;
        int        i;
        for (i = 0; i < 4; i++)
        begin
            if ($urandom_range(0, 3) == 0) p[8 * i +: 8] = 8'(8'h30 + $urandom_range(0, 9));
            else p[8 * i +: 8] = 8'($urandom_range(0, 255));
        end
        return p;
    endfunction

    // Start pattern, body, end pattern, then the decimal sum; spoil corrupts one digit.
    function automatic void queue_frame_with(input byte_q_t body, input bit spoil);
        byte_q_t  fb;
        bit [7:0] total;
        bit [7:0] digs[3];
        int       sl, el, nd, k, pick;
        sl = eff_len(st_len);
        el = eff_len(en_len);
        for (k = 0; k < sl; k++) fb.push_back(pat_byte(st_pat, sl, k));
        foreach (body[i]) fb.push_back(body[i]);
        for (k = 0; k < el; k++) fb.push_back(pat_byte(en_pat, el, k));
        total = '0;
        foreach (fb[i])
        begin
            total += fb[i];
            push_byte(fb[i]);
        end
        digs[0] = 8'(32'h30 + int'(total) / 100);
        digs[1] = 8'(32'h30 + (int'(total) / 10) % 10);
        digs[2] = 8'(32'h30 + int'(total) % 10);
        nd = (total >= 100) ? 3 : ((total >= 10) ? 2 : 1);
        if (spoil)
        begin
            pick = 3 - nd + int'($urandom_range(0, nd - 1));
            // either a wrong digit or a byte that is no digit at all
            if ($urandom_range(0, 1) == 0)
                digs[pick] = 8'(32'h30 +
                                (int'(digs[pick]) - 32'h30 + int'($urandom_range(1, 9))) % 10);
            else
                digs[pick] = digs[pick] ^ (8'h10 << $urandom_range(0, 3));
        end
        for (k = 3 - nd; k < 3; k++) push_byte(digs[k]);
    endfunction

    function automatic void queue_random_frame(input bit spoil);
        byte_q_t body;
        int      n, k;
        n = ($urandom_range(0, 99) < 85) ? int'($urandom_range(0, 6)) :
                                           int'($urandom_range(7, 40));
        for (k = 0; k < n; k++) body.push_back(clean_byte());
        queue_frame_with(body, spoil);
    endfunction

    function automatic void queue_start_only(input int n);
        int sl, k;
        sl = eff_len(st_len);
        for (k = 0; k < sl; k++) push_byte(pat_byte(st_pat, sl, k));
        for (k = 0; k < n; k++) push_byte(clean_byte());
    endfunction

    function automatic void queue_end_only();
        int el, k;
        el = eff_len(en_len);
        for (k = 0; k < el; k++) push_byte(pat_byte(en_pat, el, k));
    endfunction

    // Idle length for either side: mostly none, some short, a few long,
    // and now and then a long stretch with no idling at all.
    function automatic int idle_span(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 4)
        begin
            calm = int'($urandom_range(20, 60));
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return int'($urandom_range(1, 3));
        return int'($urandom_range(6, 24));
    endfunction

    // ------------------------------------------------------------------
    // Register writes: only issued while the block is drained, though a frame may still be open.
    // ------------------------------------------------------------------
    task automatic write_reg(input dfcd_pkg::cfg_idx_t idx, input bit [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            dfcd_pkg::CFG_START_PATTERN: st_pat = value;
            dfcd_pkg::CFG_START_LENGTH:  st_len = value[2:0];
            dfcd_pkg::CFG_END_PATTERN:   en_pat = value;
            dfcd_pkg::CFG_END_LENGTH:    en_len = value[2:0];
            default: ;
        endcase
    endtask

    // Length registers get random upper bits; only bits 2..0 are kept.
    task automatic load_patterns(input bit [31:0] sp, input bit [2:0] sl,
                                 input bit [31:0] ep, input bit [2:0] el);
        write_reg(dfcd_pkg::CFG_START_PATTERN, sp);
        write_reg(dfcd_pkg::CFG_START_LENGTH, {29'($urandom_range(0, 32'h1FFF_FFFF)), sl});
        write_reg(dfcd_pkg::CFG_END_PATTERN, ep);
        write_reg(dfcd_pkg::CFG_END_LENGTH, {29'($urandom_range(0, 32'h1FFF_FFFF)), el});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every queued byte went in and every owed event came out, then wait out
    // the requested hold: a byte that causes nothing may still be in flight.
    task automatic drain_and_hold(input int hold);
        do @(posedge clk);
        while (n_accepted != n_queued || deframe_out_q.size() != 0);
        repeat (hold) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Byte driver: offer the next queued byte, hold it until accepted,
    // then idle for a random number of cycles.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= '0;
            tx_gap  = 0;
            tx_calm = 0;
        end
        else
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                deframe_step(rx_ch.rx_byte);
                n_accepted++;
            end
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    rx_ch.valid <= 1'b0;
                end
                else if (rx_stream_q.size() != 0)
                begin
                    rx_ch.valid   <= 1'b1;
                    rx_ch.rx_byte <= rx_stream_q.pop_front();
                    tx_gap = idle_span(tx_calm);
                end
                else
                begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted beat with the oldest owed event,
    // and stall the result channel at random.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            sink_stall = 0;
            sink_calm  = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (deframe_out_q.size() == 0)
                begin
                    $display("%0t: unexpected beat kind %0d data %02h last %0b",
                             $time, res_ch.kind, res_ch.data, res_ch.last);
                    n_errors++;
                end
                else
                begin
                    want = deframe_out_q.pop_front();
                    if (res_ch.kind !== want.kind || res_ch.data !== want.data ||
                        res_ch.last !== want.last)
                    begin
                        $display("%0t: expected kind %s data %02h last %0b, got kind %0d data %02h last %0b",
                                 $time, want.kind.name(), want.data, want.last,
                                 res_ch.kind, res_ch.data, res_ch.last);
                        n_errors++;
                    end
                end
            end
            if (sink_stall > 0)
            begin
                sink_stall--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                sink_stall = idle_span(sink_calm);
            end
        end
    end

    // Watchdog
    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= RUN_LIMIT);
        $display("tb_delimited_frame_checksum_deframer: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed frames, then phases of random traffic,
    // each under its own pattern setting.
    // ------------------------------------------------------------------
    initial
    begin
        int        ph, budget, sel, k;
        bit [31:0] sp, ep;
        bit [2:0]  sl3, el3;
        byte_q_t   body;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= dfcd_pkg::CFG_START_PATTERN;
        cfg_data  <= '0;
        // Model state after reset: '$' opens, newline closes.
        st_pat  = 32'd36;
        st_len  = 3'd1;
        en_pat  = 32'd10;
        en_len  = 3'd1;
        hist    = '0;
        hist_n  = 0;
        fstate  = HUNT;
        fsum    = '0;
        flen    = 0;
        dig_k   = 0;
        dig_bad = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset patterns. Newline while hunting must be ignored.
        push_byte(8'h0A);
        // Sum wraps to zero: a single '0' digit, body holds 00, FF and D3.
        body = '{8'h00, 8'hFF, 8'hD3};
        queue_frame_with(body, 1'b0);
        // Empty body, corrupted checksum.
        body = {};
        queue_frame_with(body, 1'b1);
        // Start inside a frame: drop "$a", restart with "$b\n", sum 144.
        push_byte(8'h24);
        push_byte(8'h61);
        body = '{8'h62};
        queue_frame_with(body, 1'b0);
        drain_and_hold(8);

        // Start "AB", end "B": both complete on the same byte, sum 131.
        load_patterns(32'h0000_4142, 3'd2, 32'h0000_0042, 3'd1);
        push_byte(8'h41);
        push_byte(8'h42);
        push_byte(8'h31);
        push_byte(8'h33);
        push_byte(8'h31);
        drain_and_hold(8);

        // Start '$' with length 0 (acts as 1), end "X$" reaching back before the frame:
        // must not close it. The frame stays open into the next phase.
        load_patterns(32'h0000_0024, 3'd0, 32'h0000_5824, 3'd2);
        push_byte(8'h58);
        push_byte(8'h24);
        push_byte(8'h51);

        for (ph = 0; ph < 7; ph++)
        begin
            drain_and_hold(8);
            case (ph)
                0:
                begin
                    // digit as start byte, oversized end length
                    sp = rand_pattern();
                    sp[7:0] = 8'h31;
                    sl3 = 3'd0;
                    ep = rand_pattern();
                    el3 = 3'd7;
                end
                1:
                begin
                    sp = 32'hFFFF_FFFF;
                    sl3 = 3'd4;
                    ep = 32'h0000_0000;
                    el3 = 3'd4;
                end
                2:
                begin
                    sp = rand_pattern();
                    sl3 = 3'd5;
                    ep = rand_pattern();
                    el3 = 3'd0;
                end
                3:
                begin
                    sp = rand_pattern();
                    sp[7:0] = 8'h24;
                    sl3 = 3'd1;
                    ep = rand_pattern();
                    ep[7:0] = 8'h0A;
                    el3 = 3'd1;
                end
                5:
                begin
                    // same bytes for both patterns
                    sp = rand_pattern();
                    sl3 = 3'($urandom_range(0, 7));
                    ep = sp;
                    el3 = 3'($urandom_range(0, 7));
                end
                default:
                begin
                    sp = rand_pattern();
                    sl3 = 3'($urandom_range(0, 7));
                    ep = rand_pattern();
                    el3 = 3'($urandom_range(0, 7));
                end
            endcase
            load_patterns(sp, sl3, ep, el3);

            // One frame that runs past the length limit and gets dropped.
            if (ph == 3) queue_start_only(dfcd_pkg::MAX_FRAME_DEF + 3 - eff_len(st_len));

            budget = n_queued + 14;
            while (n_queued < budget)
            begin
                sel = int'($urandom_range(0, 99));
                if (sel < 58)
                begin
                    queue_random_frame(1'b0);
                end
                else if (sel < 70)
                begin
                    queue_random_frame(1'b1);
                end
                else if (sel < 80)
                begin
                    // abandoned frame, restarted by the next start pattern
                    queue_start_only(int'($urandom_range(0, 5)));
                    queue_random_frame(1'b0);
                end
                else if (sel < 92)
                begin
                    for (k = int'($urandom_range(1, 6)); k > 0; k--)
                        push_byte(8'($urandom_range(0, 255)));
                end
                else
                begin
                    queue_end_only();
                end
            end
        end

        drain_and_hold(20);
        if (n_errors == 0)
            $display("tb_delimited_frame_checksum_deframer: PASS");
        else
            $display("tb_delimited_frame_checksum_deframer: FAIL");
        $finish;
    end

endmodule
